[rtl/core/lbpe_pkg.sv]
`default_nettype none

package lbpe_pkg;

	localparam int NUM_LEDS  = 4;
	localparam int LED_IDX_W = 2;
	localparam int MODE_W    = 4;
	localparam int CNT_W     = 4;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	// warning modes stop toggling once the count passes these
	localparam logic [CNT_W-1:0] SHORT_LAST = CNT_W'(2);
	localparam logic [CNT_W-1:0] LONG_LAST  = CNT_W'(12);

	localparam logic [CFG_W-1:0] FAST_RST   = CFG_W'(100);
	localparam logic [CFG_W-1:0] MEDIUM_RST = CFG_W'(500);
	localparam logic [CFG_W-1:0] SLOW_RST   = CFG_W'(2000);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FAST   = 2'd0,
		CFG_MEDIUM = 2'd1,
		CFG_SLOW   = 2'd2
	} cfg_idx_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_OFF    = 4'd0,
		MODE_ON     = 4'd1,
		MODE_WAIT   = 4'd2,
		MODE_WSHORT = 4'd3,
		MODE_WLONG  = 4'd4,
		MODE_ERROR  = 4'd5,
		MODE_IFAST  = 4'd6,
		MODE_ISLOW  = 4'd7,
		MODE_ADV    = 4'd8
	} mode_t;

	typedef struct packed {
		logic [CFG_W-1:0] fast;
		logic [CFG_W-1:0] mid;
		logic [CFG_W-1:0] slow;
	} period_cfg_t;

	typedef struct packed {
		logic              en;
		logic              start;
		logic              tick;
		logic [MODE_W-1:0] mode;
	} chan_ctl_t;

endpackage

`default_nettype wire

[rtl/core/lbpe_channel.sv]
`default_nettype none

module lbpe_channel
	import lbpe_pkg::*;
#(
	parameter int PERIOD_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire chan_ctl_t   ctl,
	input  wire period_cfg_t per,
	output logic             level_next
);

	logic [MODE_W-1:0]      mode_q, mode_n;
	logic                   level_q, level_n;
	logic [CNT_W-1:0]       count_q, count_n;
	logic                   running_q, running_n;
	logic [PERIOD_BITS-1:0] period_q, period_n;
	logic [PERIOD_BITS-1:0] left_q, left_n;

	logic [PERIOD_BITS-1:0] fast_p, medium_p, slow_p;

	assign fast_p   = PERIOD_BITS'(per.fast);
	assign medium_p = PERIOD_BITS'(per.mid);
	assign slow_p   = PERIOD_BITS'(per.slow);

	always_comb begin
		mode_n    = mode_q;
		level_n   = level_q;
		count_n   = count_q;
		running_n = running_q;
		period_n  = period_q;
		left_n    = left_q;
		if (ctl.start) begin
			mode_n    = ctl.mode;
			count_n   = '0;
			level_n   = (ctl.mode == MODE_ON);
			running_n = 1'b0;
			case (ctl.mode)
				MODE_WAIT: begin
					running_n = 1'b1;
					period_n  = medium_p;
					left_n    = medium_p;
				end
				MODE_WSHORT, MODE_WLONG, MODE_IFAST, MODE_ISLOW, MODE_ADV: begin
					running_n = 1'b1;
					period_n  = fast_p;
					left_n    = fast_p;
				end
				default: ;
			endcase
		end else if (ctl.tick && running_q) begin
			if (left_q <= PERIOD_BITS'(1)) begin
				// timer ran out: apply mode rule, then reload if still running
				case (mode_q)
					MODE_OFF: begin
						running_n = 1'b0;
						count_n   = '0;
						level_n   = 1'b0;
					end
					MODE_ON: level_n = 1'b1;
					MODE_WAIT, MODE_ERROR: level_n = !level_q;
					MODE_WSHORT: begin
						if (count_q > SHORT_LAST) begin
							running_n = 1'b0;
							mode_n    = MODE_OFF;
							count_n   = '0;
							level_n   = 1'b0;
						end else begin
							count_n = count_q + CNT_W'(1);
							level_n = !level_q;
						end
					end
					MODE_WLONG: begin
						if (count_q > LONG_LAST) begin
							running_n = 1'b0;
							mode_n    = MODE_ON;
							count_n   = '0;
							level_n   = 1'b1;
						end else begin
							count_n = count_q + CNT_W'(1);
							level_n = !level_q;
						end
					end
					MODE_IFAST: begin
						period_n = level_q ? fast_p : medium_p;
						level_n  = !level_q;
					end
					MODE_ISLOW: begin
						period_n = level_q ? fast_p : slow_p;
						level_n  = !level_q;
					end
					MODE_ADV: begin
						period_n = medium_p;
						level_n  = !level_q;
					end
					default: ;
				endcase
				if (running_n) begin
					left_n = period_n;
				end
			end else begin
				left_n = left_q - PERIOD_BITS'(1);
			end
		end
	end

	assign level_next = level_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_OFF;
			level_q   <= 1'b0;
			count_q   <= '0;
			running_q <= 1'b0;
		end else if (ctl.en) begin
			mode_q    <= mode_n;
			level_q   <= level_n;
			count_q   <= count_n;
			running_q <= running_n;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			period_q <= period_n;
			left_q   <= left_n;
		end
	end

	// a running timer only ever belongs to a blinking mode
	assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> (mode_q == MODE_WAIT || mode_q == MODE_WSHORT ||
			mode_q == MODE_WLONG || mode_q == MODE_IFAST ||
			mode_q == MODE_ISLOW || mode_q == MODE_ADV))
		else $error("timer running in a non-blinking mode");

	// off mode keeps the led dark and the timer stopped
	assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_OFF) |-> (!level_q && !running_q))
		else $error("off mode with level or timer active");

	// toggle count never goes more than one past the long warning limit
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LONG_LAST + CNT_W'(1))
		else $error("toggle count out of range");

endmodule

`default_nettype wire

[rtl/core/led_blink_pattern_engine_unit.sv]
`default_nettype none

// led blink pattern engine: four independent led channels, each with a mode,
// a level, a toggle count and a period timer counted in millisecond ticks.
// an input word with tuser high is a start command: it restarts the led named
// in tdata in the given mode (off, on, waiting, short warning, long warning,
// error, idle fast, idle slow, advertise); blinking modes load their timer
// from the fast/medium period registers then. a tuser-low word is one
// millisecond tick: every running timer counts down and one that runs out
// applies its mode rule and reloads if still running. every input word
// yields one output word with the levels of all leds after it, one word per
// clock unless the output stalls, via the input register, then the output
// register. a stalled output holds its word while one more input word waits
// in the input register. the user must write period registers through
// cfg_we/cfg_index/cfg_wdata while idle; the block does not enforce it. a
// written period applies at the next timer start or idle/advertise reload.
module led_blink_pattern_engine_unit
	import lbpe_pkg::*;
#(
	parameter int PERIOD_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// config write port
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	// input words
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [7:0]           s_tdata,   // [1:0] led_index, [5:2] led_mode
	input  wire logic                 s_tuser,   // func: 0 tick, 1 start command
	// output words
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [7:0]                m_tdata    // [3:0] led_levels
);

	// period registers
	period_cfg_t per_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			per_q.fast <= FAST_RST;
			per_q.mid  <= MEDIUM_RST;
			per_q.slow <= SLOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FAST:   per_q.fast <= cfg_wdata;
				CFG_MEDIUM: per_q.mid  <= cfg_wdata;
				CFG_SLOW:   per_q.slow <= cfg_wdata;
				default: ;  // writes past the register list are dropped
			endcase
		end
	end

	// input register
	logic                 valid_s1;
	logic                 func_s1;
	logic [LED_IDX_W-1:0] idx_s1;
	logic [MODE_W-1:0]    mode_s1;
	logic                 in_acc;
	logic                 advance;

	logic                 out_valid_q;
	logic [NUM_LEDS-1:0]  levels_q;
	logic [NUM_LEDS-1:0]  levels_next;

	// stage 1 moves on when the output register is empty or being drained
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1 <= s_tuser;
			idx_s1  <= s_tdata[LED_IDX_W-1:0];
			mode_s1 <= s_tdata[LED_IDX_W +: MODE_W];
		end
	end

	// one channel per led, all updated in the same cycle
	for (genvar i = 0; i < NUM_LEDS; i++) begin : g_led
		chan_ctl_t ctl;

		assign ctl.en    = advance;
		assign ctl.start = func_s1 && (idx_s1 == LED_IDX_W'(i));
		assign ctl.tick  = !func_s1;
		assign ctl.mode  = mode_s1;

		lbpe_channel #(
			.PERIOD_BITS(PERIOD_BITS)
		) u_chan (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.per       (per_q),
			.level_next(levels_next[i])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			levels_q <= levels_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(8 - NUM_LEDS)'(0), levels_q};

	// a full input stage behind a stalled output must not take another word
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_tready) |-> !s_tready)
		else $error("input accepted while pipeline is blocked");

	// every word that leaves stage 1 shows up as an output word
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced word lost before output");

	// output word holds while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> (out_valid_q && $stable(levels_q)))
		else $error("stalled output word changed");

endmodule

`default_nettype wire
